// ===== src/msc_pkg.sv =====
// Shared package of the midpoint subdivision line clipper.
// Holds default sizes, register indexes, outcode bits and controller links.
// Used by every module of the block; depends on nothing.
package msc_pkg;

  localparam int COORD_BITS_DEF  = 16;
  localparam int STACK_DEPTH_DEF = 17;
  localparam int MAX_RESULTS     = 36;
  localparam int CNT_W           = $clog2(MAX_RESULTS + 1);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_LEFT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_RIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_BOTTOM = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_TOP    = 2'd3;

  localparam int OC_W      = 4;
  localparam int OC_ABOVE  = 3;
  localparam int OC_BELOW  = 2;
  localparam int OC_RIGHT  = 1;
  localparam int OC_LEFT   = 0;

  typedef struct packed {
    logic load;
    logic advance;
    logic take_piece;
    logic finish;
  } msc_cmd_t;

  typedef struct packed {
    logic piece_visible;
    logic do_split;
    logic level_zero;
    logic hold_valid;
    logic out_free;
  } msc_status_t;

endpackage

// ===== src/msc_datapath.sv =====
// Datapath of the line clipper: window registers, current piece, far point stack,
// held piece and output register. Imports msc_pkg; driven by msc_ctrl commands.
module msc_datapath
  import msc_pkg::*;
#(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  msc_cmd_t                     cmd,
  output msc_status_t                  status,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic signed [COORD_BITS-1:0] cfg_data,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  input  logic                         out_stall,
  output logic                         out_valid,
  output logic                         visible,
  output logic signed [COORD_BITS-1:0] piece_start_x,
  output logic signed [COORD_BITS-1:0] piece_start_y,
  output logic signed [COORD_BITS-1:0] piece_end_x,
  output logic signed [COORD_BITS-1:0] piece_end_y,
  output logic                         last_piece
);

  localparam int LVL_W = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W = $clog2(STACK_DEPTH);

  logic signed [COORD_BITS-1:0] win_left, win_right, win_bottom, win_top;
  logic signed [COORD_BITS-1:0] cur_ax, cur_ay, cur_bx, cur_by;
  logic signed [COORD_BITS-1:0] hold_ax, hold_ay, hold_bx, hold_by;
  logic                         hold_valid;
  logic [LVL_W-1:0]             level;
  logic signed [COORD_BITS-1:0] stk_x [STACK_DEPTH];
  logic signed [COORD_BITS-1:0] stk_y [STACK_DEPTH];

  logic [OC_W-1:0]              code_a, code_b;
  logic signed [COORD_BITS:0]   dx, dy, sum_x, sum_y;
  logic                         short_x, short_y, full, both_in, share;
  logic [LVL_W-1:0]             lvl_dec;
  logic [IDX_W-1:0]             push_idx, pop_idx;
  logic signed [COORD_BITS-1:0] mid_x, mid_y;
  logic                         out_free;

  always_comb begin
    code_a[OC_ABOVE] = cur_ay > win_top;
    code_a[OC_BELOW] = cur_ay < win_bottom;
    code_a[OC_RIGHT] = cur_ax > win_right;
    code_a[OC_LEFT]  = cur_ax < win_left;
    code_b[OC_ABOVE] = cur_by > win_top;
    code_b[OC_BELOW] = cur_by < win_bottom;
    code_b[OC_RIGHT] = cur_bx > win_right;
    code_b[OC_LEFT]  = cur_bx < win_left;
  end

  assign dx      = (COORD_BITS+1)'(cur_ax) - (COORD_BITS+1)'(cur_bx);
  assign dy      = (COORD_BITS+1)'(cur_ay) - (COORD_BITS+1)'(cur_by);
  assign short_x = (dx == '0) || (dx == (COORD_BITS+1)'(1)) || (dx == '1);
  assign short_y = (dy == '0) || (dy == (COORD_BITS+1)'(1)) || (dy == '1);
  assign sum_x   = (COORD_BITS+1)'(cur_ax) + (COORD_BITS+1)'(cur_bx);
  assign sum_y   = (COORD_BITS+1)'(cur_ay) + (COORD_BITS+1)'(cur_by);
  assign mid_x   = sum_x[COORD_BITS:1];
  assign mid_y   = sum_y[COORD_BITS:1];

  assign full     = level == LVL_W'(STACK_DEPTH);
  assign both_in  = (code_a == '0) && (code_b == '0);
  assign share    = |(code_a & code_b);
  assign lvl_dec  = level - LVL_W'(1);
  assign push_idx = level[IDX_W-1:0];
  assign pop_idx  = lvl_dec[IDX_W-1:0];
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    status.piece_visible = both_in;
    status.do_split      = !both_in && !share && !(short_x && short_y) && !full;
    status.level_zero    = level == '0;
    status.hold_valid    = hold_valid;
    status.out_free      = out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_left   <= '0;
      win_right  <= '0;
      win_bottom <= '0;
      win_top    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIN_LEFT:   win_left   <= cfg_data;
        REG_WIN_RIGHT:  win_right  <= cfg_data;
        REG_WIN_BOTTOM: win_bottom <= cfg_data;
        REG_WIN_TOP:    win_top    <= cfg_data;
        default:        win_left   <= win_left;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level  <= '0;
      cur_ax <= '0;
      cur_ay <= '0;
      cur_bx <= '0;
      cur_by <= '0;
    end else if (cmd.load) begin
      level  <= '0;
      cur_ax <= start_x;
      cur_ay <= start_y;
      cur_bx <= end_x;
      cur_by <= end_y;
    end else if (cmd.advance) begin
      if (status.do_split) begin
        level  <= level + LVL_W'(1);
        cur_bx <= mid_x;
        cur_by <= mid_y;
      end else if (level != '0) begin
        level  <= lvl_dec;
        cur_ax <= cur_bx;
        cur_ay <= cur_by;
        cur_bx <= stk_x[pop_idx];
        cur_by <= stk_y[pop_idx];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.advance && status.do_split) begin
      stk_x[push_idx] <= cur_bx;
      stk_y[push_idx] <= cur_by;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (cmd.load || cmd.finish) begin
      hold_valid <= 1'b0;
    end else if (cmd.take_piece) begin
      hold_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_piece) begin
      hold_ax <= cur_ax;
      hold_ay <= cur_ay;
      hold_bx <= cur_bx;
      hold_by <= cur_by;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish || (cmd.take_piece && hold_valid)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      visible       <= hold_valid;
      last_piece    <= 1'b1;
      piece_start_x <= hold_valid ? hold_ax : '0;
      piece_start_y <= hold_valid ? hold_ay : '0;
      piece_end_x   <= hold_valid ? hold_bx : '0;
      piece_end_y   <= hold_valid ? hold_by : '0;
    end else if (cmd.take_piece && hold_valid) begin
      visible       <= 1'b1;
      last_piece    <= 1'b0;
      piece_start_x <= hold_ax;
      piece_start_y <= hold_ay;
      piece_end_x   <= hold_bx;
      piece_end_y   <= hold_by;
    end
  end

endmodule

// ===== src/msc_ctrl.sv =====
// Controller of the line clipper: state machine and count of visible pieces.
// Imports msc_pkg; reads msc_datapath status and issues its commands.
module msc_ctrl
  import msc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  msc_status_t status,
  output msc_cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_RUN    = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]       state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic             step_blocked;

  assign in_stall     = state != ST_IDLE;
  assign step_blocked = status.piece_visible && status.hold_valid && !status.out_free;

  always_comb begin
    state_next = state;
    count_next = count;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          count_next = '0;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!step_blocked) begin
          cmd.advance    = 1'b1;
          cmd.take_piece = status.piece_visible;
          if (status.piece_visible) begin
            count_next = count + CNT_W'(1);
          end
          if ((status.piece_visible && count == CNT_W'(MAX_RESULTS - 1)) ||
              (!status.do_split && status.level_zero)) begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

endmodule

// ===== src/midpoint_subdivision_line_clipper_core.sv =====
// Channel   Handshake              Request contents
// in        in_valid / in_stall    start_x, start_y, end_x, end_y
// out       out_valid / out_stall  visible, piece_start/end x and y, last_piece
// cfg       cfg_valid / cfg_ready  cfg_index, cfg_data (window edge)
// A line takes a load step, then subdivision steps (split, emit, drop or pop of
// the far point stack), then a closing step. The step loop over the stack sets
// how long a line takes.
// Reset is synchronous and needs no clearing pass; the stack is written before use.
// A stalled output holds the step loop only when a visible piece must move out.
// Top level of the midpoint subdivision line clipper; imports msc_pkg and
// instantiates msc_ctrl and msc_datapath.
module midpoint_subdivision_line_clipper_core
  import msc_pkg::*;
#(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic signed [COORD_BITS-1:0] cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         visible,
  output logic signed [COORD_BITS-1:0] piece_start_x,
  output logic signed [COORD_BITS-1:0] piece_start_y,
  output logic signed [COORD_BITS-1:0] piece_end_x,
  output logic signed [COORD_BITS-1:0] piece_end_y,
  output logic                         last_piece
);

  msc_cmd_t    cmd;
  msc_status_t status;

  assign cfg_ready = 1'b1;

  msc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  msc_datapath #(
    .COORD_BITS  (COORD_BITS),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .start_x       (start_x),
    .start_y       (start_y),
    .end_x         (end_x),
    .end_y         (end_y),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .visible       (visible),
    .piece_start_x (piece_start_x),
    .piece_start_y (piece_start_y),
    .piece_end_x   (piece_end_x),
    .piece_end_y   (piece_end_y),
    .last_piece    (last_piece)
  );

endmodule

// ===== src/msc_checker.sv =====
// Port-level checks of the line clipper core, attached by a bind statement.
// Imports msc_pkg; sees only the top level's ports.
module msc_checker
  import msc_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         visible,
  input logic signed [COORD_BITS-1:0] piece_start_x,
  input logic signed [COORD_BITS-1:0] piece_start_y,
  input logic signed [COORD_BITS-1:0] piece_end_x,
  input logic signed [COORD_BITS-1:0] piece_end_y,
  input logic                         last_piece
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(piece_start_x) &&
      $stable(piece_end_x) && $stable(last_piece))
    else $error("Stalled result changed.");

  a_reject_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && !visible |-> last_piece && piece_start_x == '0 &&
      piece_start_y == '0 && piece_end_x == '0 && piece_end_y == '0)
    else $error("Rejected line result is malformed.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("Core accepted a line without becoming busy.");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("Reset did not clear the handshakes.");

endmodule

bind midpoint_subdivision_line_clipper_core msc_checker #(
  .COORD_BITS (COORD_BITS)
) u_msc_checker (.*);
